// ===== src/tced_pkg.sv =====
package tced_pkg;

  localparam logic [6:0] CARET = 7'd94;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    P_NONE = 2'd0,
    P_ONE  = 2'd1,
    P_TWO  = 2'd2,
    P_HEX  = 2'd3
  } pend_e;

  typedef struct packed {
    logic [6:0] char_in;
    logic       last_in;
  } in_t;

  typedef struct packed {
    logic [7:0] token;
    logic       last_out;
  } out_t;

  typedef struct packed {
    logic [1:0] n;
    out_t       tok0;
    out_t       tok1;
    pend_e      pend_d;
    logic [6:0] held_d;
  } dec_t;

endpackage

// ===== src/tced_decode.sv =====
module tced_decode (
  input  tced_pkg::in_t   in_i,
  input  tced_pkg::pend_e pend_i,
  input  logic [6:0]      held_i,
  output tced_pkg::dec_t  dec_o
);

  function automatic logic is_hex(input logic [6:0] c);
    return (c >= 7'd48 && c <= 7'd57) || (c >= 7'd97 && c <= 7'd102);
  endfunction

  function automatic logic [3:0] hex_val(input logic [6:0] c);
    logic [6:0] v;
    v = (c <= 7'd57) ? (c - 7'd48) : (c - 7'd87);
    return v[3:0];
  endfunction

  function automatic logic [7:0] shift64(input logic [6:0] c);
    return {1'b0, ~c[6], c[5:0]};
  endfunction

  logic [6:0] c;
  logic [7:0] x;
  logic [1:0] n;
  logic [7:0] t0;
  logic [7:0] t1;
  tced_pkg::pend_e pend;
  logic [6:0] held;

  assign c = in_i.char_in;

  always_comb begin
    n    = 2'd0;
    t0   = 8'd0;
    t1   = 8'd0;
    pend = pend_i;
    held = held_i;
    x    = 8'd0;
    case (pend_i)
      tced_pkg::P_NONE: begin
        if (c == tced_pkg::CARET) begin
          pend = tced_pkg::P_ONE;
        end else begin
          t0 = {1'b0, c};
          n  = 2'd1;
        end
      end
      tced_pkg::P_ONE: begin
        if (c == tced_pkg::CARET) begin
          pend = tced_pkg::P_TWO;
        end else begin
          t0   = {1'b0, tced_pkg::CARET};
          t1   = {1'b0, c};
          n    = 2'd2;
          pend = tced_pkg::P_NONE;
        end
      end
      tced_pkg::P_TWO: begin
        if (is_hex(c)) begin
          held = c;
          pend = tced_pkg::P_HEX;
        end else begin
          x = shift64(c);
          if (x == {1'b0, tced_pkg::CARET}) begin
            pend = tced_pkg::P_ONE;
          end else begin
            t0   = x;
            n    = 2'd1;
            pend = tced_pkg::P_NONE;
          end
        end
      end
      tced_pkg::P_HEX: begin
        held = 7'd0;
        if (is_hex(c)) begin
          x = {hex_val(held_i), hex_val(c)};
          if (x == {1'b0, tced_pkg::CARET}) begin
            pend = tced_pkg::P_ONE;
          end else begin
            t0   = x;
            n    = 2'd1;
            pend = tced_pkg::P_NONE;
          end
        end else begin
          t0 = shift64(held_i);
          n  = 2'd1;
          if (c == tced_pkg::CARET) begin
            pend = tced_pkg::P_ONE;
          end else begin
            t1   = {1'b0, c};
            n    = 2'd2;
            pend = tced_pkg::P_NONE;
          end
        end
      end
      default: begin
        pend = tced_pkg::P_NONE;
      end
    endcase

    // flush whatever is pending on the final character
    if (in_i.last_in) begin
      case (pend)
        tced_pkg::P_ONE: begin
          if (n == 2'd0) begin
            t0 = {1'b0, tced_pkg::CARET};
          end else begin
            t1 = {1'b0, tced_pkg::CARET};
          end
          n = n + 2'd1;
        end
        tced_pkg::P_TWO: begin
          t0 = {1'b0, tced_pkg::CARET};
          t1 = {1'b0, tced_pkg::CARET};
          n  = 2'd2;
        end
        tced_pkg::P_HEX: begin
          t0 = shift64(held);
          n  = 2'd1;
        end
        default: begin
        end
      endcase
      pend = tced_pkg::P_NONE;
      held = 7'd0;
    end
  end

  assign dec_o.n             = n;
  assign dec_o.tok0.token    = t0;
  assign dec_o.tok0.last_out = in_i.last_in && (n == 2'd1);
  assign dec_o.tok1.token    = t1;
  assign dec_o.tok1.last_out = in_i.last_in && (n == 2'd2);
  assign dec_o.pend_d        = pend;
  assign dec_o.held_d        = held;

endmodule

// ===== src/tex_caret_escape_decoder.sv =====
// Caret-caret escape decoder.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one 7-bit
// character per transaction with a flag on the final character of a text.
// Output channel (out_valid_o / out_ready_i / out_data_o) gives decoded
// token codes; last_out marks the final token of the text.
//
// One character is accepted per cycle while in_ready_o is high. Its tokens
// (zero, one or two) enter a four-entry result queue in the same edge and
// are registered there; the queue drains at one token per cycle while
// out_ready_i is high. Sustained rate is one character per cycle while the
// receiver is ready and characters yield at most one token on average.
//
// in_ready_o is high while the queue has room for two tokens, so a stalled
// receiver backs up the queue and then the input; no token is dropped.
// Reset empties the queue and clears the pending caret prefix and digit.
module tex_caret_escape_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tced_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tced_pkg::out_t out_data_o
);

  tced_pkg::pend_e pend_q;
  logic [6:0] held_q;
  tced_pkg::dec_t dec;

  tced_pkg::out_t mem_q [tced_pkg::FIFO_DEPTH];
  logic [tced_pkg::PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [tced_pkg::CNT_W-1:0] count_q, count_d;
  logic [tced_pkg::CNT_W-1:0] push_n;
  logic accept, pop;

  tced_decode u_decode (
    .in_i   (in_data_i),
    .pend_i (pend_q),
    .held_i (held_q),
    .dec_o  (dec)
  );

  assign in_ready_o  = count_q <= tced_pkg::CNT_W'(tced_pkg::FIFO_DEPTH - 2);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rptr_q];

  assign push_n  = accept ? tced_pkg::CNT_W'(dec.n) : '0;
  assign wptr_d  = wptr_q + push_n[tced_pkg::PTR_W-1:0];
  assign rptr_d  = pop ? rptr_q + 1'b1 : rptr_q;
  assign count_d = count_q + push_n - tced_pkg::CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= tced_pkg::P_NONE;
      held_q  <= 7'd0;
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (accept) begin
        pend_q <= dec.pend_d;
        held_q <= dec.held_d;
      end
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && dec.n != 2'd0) begin
      mem_q[wptr_q] <= dec.tok0;
    end
    if (accept && dec.n == 2'd2) begin
      mem_q[wptr_q + 1'b1] <= dec.tok1;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tced_pkg::CNT_W'(tced_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.last_in |-> dec.n != 2'd0)
    else $error("final character gave no token");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.last_in |=> pend_q == tced_pkg::P_NONE && held_q == 7'd0)
    else $error("pending state not cleared after final character");

  a_held_only_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != tced_pkg::P_HEX |-> held_q == 7'd0)
    else $error("held digit outside hex state");

endmodule
